// ===== rtl/core/mbq_pkg.sv =====
// Shared types, codes and microcode ROM for the multichannel biquad.
package mbq_pkg;

  localparam int COEF_W   = 28;
  localparam int DLY_W    = 32;
  localparam int SMP_W    = 24;
  localparam int PROD_W   = COEF_W + DLY_W;
  localparam int ACC_W    = 62;
  localparam int RND_W    = ACC_W - 22;
  localparam int STEP_W   = 4;
  localparam int REG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] FF0_RESET = 28'sd4194304;

  // register indexes, also used as multiplier coefficient selects
  localparam logic [REG_IDX_W-1:0] REG_FF0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FB1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB2 = 3'd4;

  localparam logic [1:0] OPND_Z1 = 2'd0;
  localparam logic [1:0] OPND_Z2 = 2'd1;
  localparam logic [1:0] OPND_W  = 2'd2;

  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_LOAD_X = 3'd1;
  localparam logic [2:0] ACC_SUB    = 3'd2;
  localparam logic [2:0] ACC_ADD    = 3'd3;
  localparam logic [2:0] ACC_LOAD_P = 3'd4;

  localparam logic [STEP_W-1:0] STEP_ZERO = 4'd8;

  typedef struct packed {
    logic [REG_IDX_W-1:0] coef_sel;
    logic [1:0]           opnd_sel;
    logic [2:0]           acc_op;
    logic                 w_load;
    logic                 y_load;
    logic                 y_zero;
    logic                 mem_read;
    logic                 mem_write;
    logic                 clr_valid;
    logic                 jump_special;
    logic                 last;
    logic [STEP_W-1:0]    target;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic adv;
  } ctl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] ff0;
    logic signed [COEF_W-1:0] ff1;
    logic signed [COEF_W-1:0] ff2;
    logic signed [COEF_W-1:0] fb1;
    logic signed [COEF_W-1:0] fb2;
  } coef_bank_t;

  function automatic ucw_t ucode(logic [STEP_W-1:0] step);
    ucw_t cw;
    cw = '0;
    unique case (step)
      4'd0: begin
        cw.mem_read     = 1'b1;
        cw.jump_special = 1'b1;
        cw.target       = STEP_ZERO;
      end
      4'd1: begin
        cw.coef_sel = REG_FB1;
        cw.opnd_sel = OPND_Z1;
        cw.acc_op   = ACC_LOAD_X;
      end
      4'd2: begin
        cw.coef_sel = REG_FB2;
        cw.opnd_sel = OPND_Z2;
        cw.acc_op   = ACC_SUB;
      end
      4'd3: begin
        cw.coef_sel = REG_FF1;
        cw.opnd_sel = OPND_Z1;
        cw.acc_op   = ACC_SUB;
      end
      4'd4: begin
        cw.coef_sel = REG_FF2;
        cw.opnd_sel = OPND_Z2;
        cw.acc_op   = ACC_LOAD_P;
        cw.w_load   = 1'b1;
      end
      4'd5: begin
        cw.coef_sel  = REG_FF0;
        cw.opnd_sel  = OPND_W;
        cw.acc_op    = ACC_ADD;
        cw.mem_write = 1'b1;
      end
      4'd6: begin
        cw.acc_op = ACC_ADD;
      end
      4'd7: begin
        cw.y_load = 1'b1;
        cw.last   = 1'b1;
      end
      STEP_ZERO: begin
        cw.y_load    = 1'b1;
        cw.y_zero    = 1'b1;
        cw.clr_valid = 1'b1;
        cw.last      = 1'b1;
      end
      default: begin
        cw.y_load = 1'b1;
        cw.y_zero = 1'b1;
        cw.last   = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/mbq_req_if.sv =====
// Request channel: op, channel and input sample with valid/ready.
interface mbq_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [3:0]        channel;
  logic signed [23:0] sample_in;

  modport source (output valid, op, channel, sample_in, input ready);
  modport sink   (input valid, op, channel, sample_in, output ready);
endinterface

// ===== rtl/core/mbq_rsp_if.sv =====
// Result channel: filtered sample with valid/ready.
interface mbq_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ===== rtl/core/mbq_datapath.sv =====
// Shared multiplier, accumulator and round/saturate datapath of the biquad.
module mbq_datapath (
  input  logic                              clk,
  input  mbq_pkg::ctl_t                     ctl,
  input  mbq_pkg::coef_bank_t               coefs,
  input  logic signed [mbq_pkg::SMP_W-1:0]  x,
  input  logic signed [mbq_pkg::DLY_W-1:0]  z1,
  input  logic signed [mbq_pkg::DLY_W-1:0]  z2,
  output logic signed [mbq_pkg::DLY_W-1:0]  w,
  output logic signed [mbq_pkg::SMP_W-1:0]  y
);
  import mbq_pkg::*;

  logic signed [COEF_W-1:0] coef;
  logic signed [DLY_W-1:0]  opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RND_W-1:0]  rnd;
  logic signed [DLY_W-1:0]  w_sat;
  logic signed [SMP_W-1:0]  y_sat;

  always_comb begin
    case (ctl.cw.coef_sel)
      REG_FF0: coef = coefs.ff0;
      REG_FF1: coef = coefs.ff1;
      REG_FF2: coef = coefs.ff2;
      REG_FB1: coef = coefs.fb1;
      REG_FB2: coef = coefs.fb2;
      default: coef = '0;
    endcase
    case (ctl.cw.opnd_sel)
      OPND_Z1: opnd = z1;
      OPND_Z2: opnd = z2;
      OPND_W:  opnd = w;
      default: opnd = '0;
    endcase
  end

  assign prod_next = coef * opnd;
  assign prod_ext  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    case (ctl.cw.acc_op)
      ACC_LOAD_X: acc_next = {{(ACC_W-SMP_W-22){x[SMP_W-1]}}, x, 22'd0};
      ACC_SUB:    acc_next = acc - prod_ext;
      ACC_ADD:    acc_next = acc + prod_ext;
      ACC_LOAD_P: acc_next = prod_ext;
      default:    acc_next = acc;
    endcase
  end

  // round half up, dropping the 22 fraction bits
  assign acc_rnd = acc + {{(ACC_W-22){1'b0}}, 1'b1, 21'd0};
  assign rnd     = acc_rnd[ACC_W-1:22];

  always_comb begin
    if (&rnd[RND_W-1:DLY_W-1] || ~|rnd[RND_W-1:DLY_W-1]) begin
      w_sat = rnd[DLY_W-1:0];
    end else begin
      w_sat = {rnd[RND_W-1], {(DLY_W-1){~rnd[RND_W-1]}}};
    end
    if (&rnd[RND_W-1:SMP_W-1] || ~|rnd[RND_W-1:SMP_W-1]) begin
      y_sat = rnd[SMP_W-1:0];
    end else begin
      y_sat = {rnd[RND_W-1], {(SMP_W-1){~rnd[RND_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod <= prod_next;
      acc  <= acc_next;
      if (ctl.cw.w_load) begin
        w <= w_sat;
      end
      if (ctl.cw.y_load) begin
        y <= ctl.cw.y_zero ? '0 : y_sat;
      end
    end
  end

endmodule

// ===== rtl/core/multichannel_biquad_df2.sv =====
// Multichannel Direct Form II biquad, microcoded around one 28x32 multiplier.
// A sample request runs the eight-step program on the single multiplier; a clear
// or a channel at or beyond CHANNELS jumps to the zeroing step. Requests are taken
// one at a time; the last step waits while a previous result is still stalled.
// Reset (synchronous): coefficients to defaults, all delay words read as zero.
module multichannel_biquad_df2 #(
  parameter int CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mbq_req_if.sink                              req,
  mbq_rsp_if.source                            rsp,
  input  logic                                 cfg_we,
  input  logic [mbq_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]           cfg_data
);
  import mbq_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  coef_bank_t               coefs;
  logic                     busy;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        step_next;
  logic                     out_valid;
  ucw_t                     cw;
  ctl_t                     ctl;
  logic                     adv;
  logic                     special;

  logic                     op_r;
  logic [3:0]               chan_r;
  logic signed [SMP_W-1:0]  x_r;
  logic [CH_W-1:0]          idx;

  logic [2*DLY_W-1:0]       dly_mem [CHANNELS];
  logic [CHANNELS-1:0]      dly_ok;
  logic [2*DLY_W-1:0]       rd;
  logic                     rd_ok;
  logic signed [DLY_W-1:0]  z1;
  logic signed [DLY_W-1:0]  z2;
  logic signed [DLY_W-1:0]  w;
  logic signed [SMP_W-1:0]  y;

  assign cw      = ucode(step);
  assign idx     = chan_r[CH_W-1:0];
  assign special = op_r || ({1'b0, chan_r} >= 5'(CHANNELS));
  assign adv     = busy && !(cw.last && out_valid && !rsp.ready);
  assign ctl     = '{cw: cw, adv: adv};

  assign step_next = (cw.jump_special && special) ? cw.target : step + 1'b1;

  assign req.ready      = !busy;
  assign rsp.valid      = out_valid;
  assign rsp.sample_out = y;

  assign z1 = rd_ok ? rd[2*DLY_W-1:DLY_W] : '0;
  assign z2 = rd_ok ? rd[DLY_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '{ff0: FF0_RESET, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FF0: coefs.ff0 <= cfg_data;
        REG_FF1: coefs.ff1 <= cfg_data;
        REG_FF2: coefs.ff2 <= cfg_data;
        REG_FB1: coefs.fb1 <= cfg_data;
        REG_FB2: coefs.fb2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      dly_ok    <= '0;
    end else begin
      if (adv && cw.last) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (req.valid && req.ready) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv) begin
        if (cw.last) begin
          busy <= 1'b0;
        end
        step <= step_next;
      end
      if (adv && cw.mem_write) begin
        dly_ok[idx] <= 1'b1;
      end
      if (adv && cw.clr_valid && op_r) begin
        dly_ok <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r   <= req.op;
      chan_r <= req.channel;
      x_r    <= req.sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cw.mem_read && !special) begin
      rd    <= dly_mem[idx];
      rd_ok <= dly_ok[idx];
    end
    if (adv && cw.mem_write) begin
      dly_mem[idx] <= {w, z1};
    end
  end

  mbq_datapath u_dp (
    .clk   (clk),
    .ctl   (ctl),
    .coefs (coefs),
    .x     (x_r),
    .z1    (z1),
    .z2    (z2),
    .w     (w),
    .y     (y)
  );

endmodule

// ===== rtl/core/mbq_checker.sv =====
// Port-level checks for the multichannel biquad, bound to the top level.
module mbq_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_op,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [23:0] rsp_sample_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while one is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
    else $error("stalled result changed");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op && !rsp_valid)
      |-> ##3 (rsp_valid && rsp_sample_out == 24'd0))
    else $error("clear did not return zero in time");

endmodule

bind multichannel_biquad_df2 mbq_checker u_mbq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.op),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_sample_out (rsp.sample_out)
);

// ===== bench/multichannel_biquad_df2_test.sv =====
// Self-checking testbench for the multichannel Direct Form II biquad.
module multichannel_biquad_df2_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbq_pkg::*;

  localparam int CHANNELS  = 8;
  localparam int REG_COUNT = 5;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam longint DLY_MAX = 64'sd2147483647;
  localparam longint DLY_MIN = -64'sd2147483648;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 28'sh7ffffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = -28'sh8000000;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7fffff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = -24'sh800000;

  typedef enum int {COEF_FULL, COEF_MODERATE, COEF_GENTLE, COEF_EXTREME} coef_style_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  mbq_req_if req_ch();
  mbq_rsp_if rsp_ch();

  multichannel_biquad_df2 #(.CHANNELS(CHANNELS)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter state mirror
  logic signed [COEF_W-1:0] coef_reg [REG_COUNT];
  logic signed [DLY_W-1:0] z1_mem [CHANNELS];
  logic signed [DLY_W-1:0] z2_mem [CHANNELS];

  logic signed [SMP_W-1:0] expected_out [$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_max = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [12:0] stall_pattern = 13'b1101100111010;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint round_q22(input longint v);
    return (v + 64'sd2097152) >>> 22;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SMP_W-1:0] biquad_predict(input logic op,
      input logic [3:0] ch, input logic signed [SMP_W-1:0] x);
    longint acc, w, y, z1, z2;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < CHANNELS; i++) begin
        z1_mem[i] = '0;
        z2_mem[i] = '0;
      end
      return '0;
    end
    if (ch >= CHANNELS) return '0;
    z1 = z1_mem[ch];
    z2 = z2_mem[ch];
    acc = (longint'(x) <<< 22) - longint'(coef_reg[REG_FB1]) * z1
          - longint'(coef_reg[REG_FB2]) * z2;
    w = saturate(round_q22(acc), DLY_MIN, DLY_MAX);
    acc = longint'(coef_reg[REG_FF0]) * w + longint'(coef_reg[REG_FF1]) * z1
          + longint'(coef_reg[REG_FF2]) * z2;
    y = saturate(round_q22(acc), OUT_MIN, OUT_MAX);
    z2_mem[ch] = z1_mem[ch];
    z1_mem[ch] = w[DLY_W-1:0];
    return y[SMP_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result(input logic signed [SMP_W-1:0] got);
    logic signed [SMP_W-1:0] want;
    if (expected_out.size() == 0) begin
      report_mismatch($sformatf("sample_out %0d with nothing expected", got));
    end else begin
      want = expected_out.pop_front();
      if (got !== want)
        report_mismatch($sformatf("sample_out %0d, expected %0d", got, want));
    end
  endtask

  // result side: check, then choose next ready
  initial begin
    int pat_idx;
    pat_idx = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result(rsp_ch.sample_out);
      case (stall_mode)
        STALL_NONE:    rsp_ch.ready <= 1'b1;
        STALL_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        default:       rsp_ch.ready <= stall_pattern[pat_idx % 13];
      endcase
      pat_idx++;
    end
  end

  task automatic send_request(input logic op, input logic [3:0] ch,
      input logic signed [SMP_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.channel <= ch;
    req_ch.sample_in <= x;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_out.push_back(biquad_predict(op, ch, x));
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // call only while idle; also pokes one unused register index
  task automatic load_coefs(input logic signed [COEF_W-1:0] a0, a1, a2, b1, b2);
    logic signed [COEF_W-1:0] vals [REG_COUNT];
    vals[REG_FF0] = a0;
    vals[REG_FF1] = a1;
    vals[REG_FF2] = a2;
    vals[REG_FB1] = b1;
    vals[REG_FB2] = b2;
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data <= vals[i];
      coef_reg[i] = vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_IDX_W'($urandom_range(REG_COUNT, (1 << REG_IDX_W) - 1));
    cfg_data <= COEF_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef(input coef_style_t style);
    logic signed [COEF_W-1:0] r;
    r = COEF_W'($urandom);
    case (style)
      COEF_FULL:     return r;
      COEF_MODERATE: return r >>> 3;
      COEF_GENTLE:   return r >>> 5;
      default: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return -28'sd1;
          default: return 28'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0, 1: return SMP_W'($urandom);
      2: return SMP_W'($urandom_range(0, 8191)) - 24'sd4096;
      default: begin
        case ($urandom_range(0, 3))
          0: return SMP_MAX;
          1: return SMP_MIN;
          2: return '0;
          default: return -24'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic test_passthrough();
    send_request(OP_SAMPLE, 4'd0, SMP_MAX);
    send_request(OP_SAMPLE, 4'd0, SMP_MIN);
    send_request(OP_SAMPLE, 4'd0, '0);
    send_request(OP_SAMPLE, 4'd0, -24'sd1);
    send_request(OP_SAMPLE, 4'd7, 24'sh2aaaaa);
    send_request(OP_SAMPLE, 4'd8, SMP_MAX);
    send_request(OP_SAMPLE, 4'd15, SMP_MIN);
    send_request(OP_CLEAR, 4'd3, SMP_MAX);
    quiesce();
  endtask

  task automatic test_saturation();
    load_coefs(COEF_MAX, '0, '0, COEF_MIN, '0);
    repeat (4) send_request(OP_SAMPLE, 4'd1, SMP_MAX);
    quiesce();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
    repeat (3) send_request(OP_SAMPLE, 4'd2, SMP_MIN);
    send_request(OP_CLEAR, 4'd12, '0);
    quiesce();
  endtask

  // a0 = 0.5 makes odd samples land on exact halves
  task automatic test_rounding();
    load_coefs(28'sd2097152, '0, '0, '0, '0);
    send_request(OP_SAMPLE, 4'd2, 24'sd1);
    send_request(OP_SAMPLE, 4'd2, -24'sd1);
    send_request(OP_SAMPLE, 4'd2, -24'sd3);
    send_request(OP_SAMPLE, 4'd5, 24'sd3);
    quiesce();
  endtask

  task automatic test_random_streams();
    coef_style_t style;
    logic op;
    logic [3:0] ch;
    for (int phase = 0; phase < 8; phase++) begin
      style = coef_style_t'(phase % 4);
      stall_mode = stall_mode_t'(phase % 3);
      gap_max = (phase % 4 == 0) ? 0 : $urandom_range(1, 8);
      load_coefs(rand_coef(style), rand_coef(style), rand_coef(style),
                 rand_coef(style), rand_coef(style));
      for (int n = 0; n < 115; n++) begin
        op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_SAMPLE;
        ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(CHANNELS, 15))
                                         : 4'($urandom_range(0, CHANNELS - 1));
        send_request(op, ch, rand_sample());
      end
      quiesce();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_SAMPLE;
    req_ch.channel <= '0;
    req_ch.sample_in <= '0;
    coef_reg[REG_FF0] = FF0_RESET;
    coef_reg[REG_FF1] = '0;
    coef_reg[REG_FF2] = '0;
    coef_reg[REG_FB1] = '0;
    coef_reg[REG_FB2] = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      z1_mem[i] = '0;
      z2_mem[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_saturation();
    test_rounding();
    test_random_streams();
    quiesce();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mbq_pkg.sv
rtl/core/mbq_req_if.sv
rtl/core/mbq_rsp_if.sv
rtl/core/mbq_datapath.sv
rtl/core/multichannel_biquad_df2.sv
rtl/core/mbq_checker.sv
bench/multichannel_biquad_df2_test.sv
